### rtl/camt_pkg.sv
// Package for the console address map translator: region codes,
// configuration register indexes, host base addresses and the config struct.
// No dependencies.
package camt_pkg;

  localparam int unsigned AddrW     = 24;
  localparam int unsigned HostW     = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 25;
  localparam int unsigned SizeLog2W = 5;
  localparam int unsigned RomPosW   = 25;

  typedef enum logic [2:0] {
    REGION_UNMAPPED = 3'd0,
    REGION_LRAM     = 3'd1,
    REGION_HRAM     = 3'd2,
    REGION_IO       = 3'd3,
    REGION_SRAM     = 3'd4,
    REGION_ROM      = 3'd5
  } region_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOROM_MODE    = 2'd0,
    CFG_ROM_SIZE_LOG2 = 2'd1,
    CFG_ROM_POSITION  = 2'd2
  } cfg_idx_e;

  localparam logic [HostW-1:0] LRAM_BASE     = 32'h0200_0000;
  localparam logic [HostW-1:0] HRAM_BASE     = 32'h0201_0000;
  localparam logic [HostW-1:0] IO_BASE       = 32'h8000_0000;
  localparam logic [HostW-1:0] SRAM_BASE     = 32'h8000_6000;
  localparam logic [HostW-1:0] ROM_HOST_BASE = 32'h0800_0000;
  localparam logic [HostW-1:0] LOROM_BANK_KEEP = ~32'h0000_7FFF;
  localparam logic [HostW-1:0] HIROM_BANK_KEEP = ~32'h0000_FFFF;

  localparam logic                 LOROM_MODE_RST    = 1'b1;
  localparam logic [SizeLog2W-1:0] ROM_SIZE_LOG2_RST = 5'd20;
  localparam logic [RomPosW-1:0]   ROM_POSITION_RST  = '0;

  typedef struct packed {
    logic                 lorom_mode;
    logic [SizeLog2W-1:0] rom_size_log2;
    logic [RomPosW-1:0]   rom_position;
  } camt_cfg_t;

endpackage

### rtl/camt_cfg.sv
// Configuration register file of the address map translator.
// Depends on camt_pkg.
module camt_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [camt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [camt_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output camt_pkg::camt_cfg_t             cfg_o
);
  import camt_pkg::*;

  camt_cfg_t cfg_q;

  // Writes to an index that names no register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lorom_mode    <= LOROM_MODE_RST;
      cfg_q.rom_size_log2 <= ROM_SIZE_LOG2_RST;
      cfg_q.rom_position  <= ROM_POSITION_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOROM_MODE:    cfg_q.lorom_mode    <= cfg_wdata_i[0];
        CFG_ROM_SIZE_LOG2: cfg_q.rom_size_log2 <= cfg_wdata_i[SizeLog2W-1:0];
        CFG_ROM_POSITION:  cfg_q.rom_position  <= cfg_wdata_i[RomPosW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/camt_translate.sv
// Combinational region decode and host address calculation for one
// console bus address. Depends on camt_pkg.
module camt_translate (
  input  logic [camt_pkg::AddrW-1:0] addr_i,
  input  camt_pkg::camt_cfg_t        cfg_i,
  output logic [camt_pkg::HostW-1:0] host_address_o,
  output camt_pkg::region_e          region_o
);
  import camt_pkg::*;

  logic [7:0]       bank;
  logic [6:0]       low_bank;
  logic [2:0]       blk;
  logic [HostW-1:0] rom_mask;
  logic [HostW-1:0] rom_base;
  logic [HostW-1:0] lo_offset;
  logic [HostW-1:0] hi_offset;
  logic [HostW-1:0] rom_addr;
  region_e          region;

  assign bank     = addr_i[23:16];
  assign low_bank = addr_i[22:16];
  assign blk      = addr_i[15:13];

  // Region decode; banks 0x80-0xBF mirror banks 0x00-0x3F.
  always_comb begin
    if (bank == 8'h7E) begin
      region = REGION_LRAM;
    end else if (bank == 8'h7F) begin
      region = REGION_HRAM;
    end else if (bank >= 8'hC0) begin
      region = REGION_ROM;
    end else if (low_bank < 7'h40) begin
      case (blk)
        3'd0:       region = REGION_LRAM;
        3'd1, 3'd2: region = REGION_IO;
        3'd3:       region = (low_bank >= 7'h30) ? REGION_SRAM : REGION_UNMAPPED;
        default:    region = REGION_ROM;
      endcase
    end else if (bank < 8'h70) begin
      if (blk[2]) region = REGION_ROM;
      else        region = cfg_i.lorom_mode ? REGION_UNMAPPED : REGION_ROM;
    end else begin
      region = blk[2] ? REGION_ROM : REGION_SRAM;
    end
  end

  // ROM offset: LoROM folds the bank into 32 KB pages, HiROM is linear.
  assign rom_mask  = (32'd1 << cfg_i.rom_size_log2) - 32'd1;
  assign rom_base  = ROM_HOST_BASE + {7'd0, cfg_i.rom_position};
  assign lo_offset = {9'd0, addr_i[23:1]} & rom_mask & LOROM_BANK_KEEP;
  assign hi_offset = {8'd0, addr_i} & rom_mask & HIROM_BANK_KEEP;

  always_comb begin
    if (cfg_i.lorom_mode) rom_addr = {17'd0, addr_i[14:0]} + lo_offset + rom_base;
    else                  rom_addr = {16'd0, addr_i[15:0]} + hi_offset + rom_base;
  end

  always_comb begin
    case (region)
      REGION_LRAM: host_address_o = LRAM_BASE | {16'd0, addr_i[15:0]};
      REGION_HRAM: host_address_o = HRAM_BASE | {16'd0, addr_i[15:0]};
      REGION_IO:   host_address_o = IO_BASE | {16'd0, addr_i[15:0]};
      REGION_SRAM: host_address_o = SRAM_BASE + {19'd0, addr_i[12:0]};
      REGION_ROM:  host_address_o = rom_addr;
      default:     host_address_o = {19'd0, addr_i[12:0]};
    endcase
  end

  assign region_o = region;

endmodule

### rtl/console_address_map_translate.sv
// Top level of the console address map translator: input register, decode
// logic and result register with stream handshakes.
// Depends on camt_pkg, camt_cfg and camt_translate.
//
//   Channel   Direction  Handshake                Contents
//   s_axis    in         tvalid / tready          tdata[23:0] bus_address
//   m_axis    out        tvalid / tready          tdata[31:0] host_address, tuser[2:0] region
//   cfg       in         cfg_we_i (no wait)       cfg_index_i, cfg_wdata_i
//
// Each address passes through the input register, then the decode and the
// ROM adder write the result register. One address is accepted every cycle
// as long as the output side keeps taking results; the two registers move as
// a pipeline.
// When the output stalls, the result register holds and the input register
// fills, after which s_axis_tready drops until the output moves again.
// Reset empties both stages and loads the register defaults: LoROM layout,
// a 1 MB ROM and a ROM base of zero.
module console_address_map_translate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,   // [23:0] bus_address
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,   // [31:0] host_address
  output logic [2:0]                      m_axis_tuser,   // [2:0] region
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [camt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [camt_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import camt_pkg::*;

  camt_cfg_t        cfg;
  logic             in_xfer;
  logic             out_free;
  logic             s1_advance;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] s1_addr_q;
  logic [HostW-1:0] xl_host;
  region_e          xl_region;
  logic [HostW-1:0] out_host_q;
  region_e          out_region_q;

  camt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  camt_translate u_translate (
    .addr_i         (s1_addr_q),
    .cfg_i          (cfg),
    .host_address_o (xl_host),
    .region_o       (xl_region)
  );

  // The result register is free when empty or when its result leaves now.
  // The input register can take a new address when empty or when its
  // address moves on into the result register in this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_advance    = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer)         s1_valid_d = 1'b1;
    else if (s1_advance) s1_valid_d = 1'b0;
  end

  assign out_valid_d = out_free ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load only on a transfer into their stage.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_addr_q <= s_axis_tdata;
    end
    if (s1_advance) begin
      out_host_q   <= xl_host;
      out_region_q <= xl_region;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_host_q;
  assign m_axis_tuser  = out_region_q;

  // A held address in the input register must not vanish while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q)
    else $error("input stage lost an address while the output was stalled");

  // A result leaving the input stage always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> m_axis_tvalid)
    else $error("result register did not capture an advancing address");

  // Low RAM results always fall in the low RAM window of the host space.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == REGION_LRAM) |-> m_axis_tdata[31:16] == 16'h0200)
    else $error("low RAM result outside its host window");

  // Save RAM results always fall in the 8 KB save RAM window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == REGION_SRAM) |-> m_axis_tdata[31:13] == 19'h40003)
    else $error("save RAM result outside its host window");

endmodule
